// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/tdsh_pkg.sv
package tdsh_pkg;

  localparam int unsigned ROW_WORDS  = 256;
  localparam int unsigned TABLE_ROWS = 5;

  // generator: s = (s * 125 + 3) mod 0x2AAAAB
  localparam logic [21:0] LCG_SEED = 22'h100001;
  localparam logic [21:0] LCG_MOD  = 22'h2AAAAB;
  localparam logic [23:0] LCG_MOD1 = 24'h2AAAAB;
  localparam logic [23:0] LCG_MOD2 = 24'h555556;
  localparam logic [23:0] LCG_INC  = 24'd3;
  // bits of 125 msb first, one per horner step; step 7 adds the increment
  localparam logic [7:0]  LCG_MULT_BITS = 8'h5F;
  localparam logic [2:0]  LCG_LAST_STEP = 3'd7;

  localparam logic [31:0] SEED_ONE_START = 32'h7FED7FED;
  localparam logic [31:0] SEED_TWO_START = 32'hEEEEEEEE;
  localparam logic [31:0] SEED_TWO_INC   = 32'd3;

  localparam logic [7:0] CHAR_END     = 8'h00;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_FOLD    = 8'h20;

  typedef struct packed {
    logic        we;
    logic [2:0]  row;
    logic [7:0]  col;
    logic [31:0] data;
  } fill_wr_t;

  typedef struct packed {
    logic        term;
    logic [7:0]  char_up;
    logic [31:0] word;
  } hash_item_t;

endpackage

// File: rtl/tdsh_fill.sv
`include "assert_macros.svh"

module tdsh_fill #(
  parameter int unsigned HASH_TYPES = 5
) (
  input  logic              clk,
  input  logic              rst,
  output tdsh_pkg::fill_wr_t wr,
  output logic              done
);
  import tdsh_pkg::*;

  localparam logic [2:0] ROW_LIMIT = 3'(HASH_TYPES);

  logic [21:0] s;
  logic [21:0] x;
  logic [2:0]  k;
  logic        half;
  logic [15:0] hi;
  logic [2:0]  row;
  logic [7:0]  col;

  logic [21:0] x_base;
  logic [23:0] t;
  logic [23:0] t_red;
  logic [21:0] x_next;

  // one horner step of s * 125 per cycle, then the increment
  always_comb begin
    x_base = (k == 3'd0) ? '0 : x;
    if (k == LCG_LAST_STEP) begin
      t = {2'b00, x} + LCG_INC;
    end else begin
      t = {1'b0, x_base, 1'b0} + (LCG_MULT_BITS[k] ? {2'b00, s} : 24'd0);
    end
    if (t >= LCG_MOD2) begin
      t_red = t - LCG_MOD2;
    end else if (t >= LCG_MOD1) begin
      t_red = t - LCG_MOD1;
    end else begin
      t_red = t;
    end
    x_next = t_red[21:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s    <= LCG_SEED;
      k    <= '0;
      half <= 1'b0;
      row  <= '0;
      col  <= '0;
      done <= 1'b0;
    end else if (!done) begin
      k <= k + 3'd1;
      if (k != LCG_LAST_STEP) begin
        x <= x_next;
      end else begin
        s <= x_next;
        if (!half) begin
          hi   <= x_next[15:0];
          half <= 1'b1;
        end else begin
          half <= 1'b0;
          if (row == 3'(TABLE_ROWS - 1)) begin
            row <= '0;
            col <= col + 8'd1;
            if (col == 8'hFF) begin
              done <= 1'b1;
            end
          end else begin
            row <= row + 3'd1;
          end
        end
      end
    end
  end

  always_comb begin
    wr.we   = !done && (k == LCG_LAST_STEP) && half && (row < ROW_LIMIT);
    wr.row  = row;
    wr.col  = col;
    wr.data = {hi, x_next[15:0]};
  end

  `ASSERT_CLK(a_done_sticks, clk, rst, done |=> done, "fill done dropped")
  `ASSERT_CLK(a_no_write_after_done, clk, rst, done |-> !wr.we, "table written after fill")

endmodule

// File: rtl/tdsh_front.sv
module tdsh_front #(
  parameter int unsigned HASH_TYPES = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  tdsh_pkg::fill_wr_t  wr,
  input  logic                fill_done,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          character,
  input  logic [2:0]          hash_type,
  output logic                item_valid,
  input  logic                item_ready,
  output tdsh_pkg::hash_item_t item
);
  import tdsh_pkg::*;

  localparam int unsigned DEPTH = HASH_TYPES * ROW_WORDS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [2:0]  ROW_LIMIT = 3'(HASH_TYPES);

  logic [31:0] mem [DEPTH];

  logic        accept;
  logic [7:0]  char_up;
  logic        oob;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;

  logic        s1_valid;
  logic        s1_term;
  logic        s1_oob;
  logic [7:0]  s1_char;
  logic [31:0] rdata;

  assign in_ready = fill_done && (!s1_valid || item_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    if (character >= CHAR_LOWER_A && character <= CHAR_LOWER_Z) begin
      char_up = character - CHAR_FOLD;
    end else begin
      char_up = character;
    end
    oob   = hash_type >= ROW_LIMIT;
    raddr = oob ? '0 : AW'({hash_type, char_up});
    waddr = AW'({wr.row, wr.col});
  end

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[waddr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (accept) begin
      s1_term <= (character == CHAR_END);
      s1_oob  <= oob;
      s1_char <= char_up;
    end
  end

  always_comb begin
    item_valid   = s1_valid;
    item.term    = s1_term;
    item.char_up = s1_char;
    // rows past the table read as zero
    item.word    = s1_oob ? 32'd0 : rdata;
  end

endmodule

// File: rtl/tdsh_queue.sv
`include "assert_macros.svh"

module tdsh_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push_valid,
  output logic                 push_ready,
  input  tdsh_pkg::hash_item_t push_item,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output tdsh_pkg::hash_item_t pop_item
);
  import tdsh_pkg::*;

  hash_item_t  entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  `ASSERT_CLK(a_count_bound, clk, rst, count != 2'd3, "queue count out of range")
  `ASSERT_CLK(a_ptr_count, clk, rst, (count == 2'd1) |-> (wr_ptr != rd_ptr),
    "queue pointers disagree with count")

endmodule

// File: rtl/tdsh_back.sv
`include "assert_macros.svh"

module tdsh_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  tdsh_pkg::hash_item_t item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          hash_value
);
  import tdsh_pkg::*;

  logic [31:0] seed_one;
  logic [31:0] seed_two;
  logic [31:0] seed_one_next;
  logic [31:0] seed_two_next;
  logic [31:0] sum_ab;
  logic [31:0] two_part;
  logic        pop;
  logic        take;

  // terminators wait for the output register, characters never do
  assign item_ready = !item.term || !out_valid || out_ready;
  assign pop        = item_valid && item_ready;
  assign take       = out_valid && out_ready;

  always_comb begin
    sum_ab        = seed_one + seed_two;
    // seed_two side that does not wait for the new seed_one
    two_part      = {24'd0, item.char_up} + seed_two + {seed_two[26:0], 5'd0} + SEED_TWO_INC;
    seed_one_next = item.word ^ sum_ab;
    seed_two_next = seed_one_next + two_part;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed_one  <= SEED_ONE_START;
      seed_two  <= SEED_TWO_START;
      out_valid <= 1'b0;
    end else begin
      if (pop && item.term) begin
        out_valid <= 1'b1;
        seed_one  <= SEED_ONE_START;
        seed_two  <= SEED_TWO_START;
      end else begin
        if (take) begin
          out_valid <= 1'b0;
        end
        if (pop) begin
          seed_one <= seed_one_next;
          seed_two <= seed_two_next;
        end
      end
    end
    if (pop && item.term) begin
      hash_value <= seed_one;
    end
  end

  `ASSERT_CLK(a_no_overwrite, clk, rst,
    (item_valid && item.term && out_valid && !out_ready) |-> !pop,
    "pending hash overwritten")
  `ASSERT_CLK(a_seed_restart, clk, rst, (pop && item.term) |=>
    (seed_one == SEED_ONE_START && seed_two == SEED_TWO_START),
    "seeds not restarted after terminator")

endmodule

// File: rtl/table_driven_string_hash_unit.sv
// channel | signals                           | word
// in      | in_valid, in_ready                | character, hash_type
// out     | out_valid, out_ready              | hash_value
//
// after reset the mixing table is generated in place: 1280 words, two
// generator draws a word, with in_ready low throughout. then one word per
// cycle unless stalled; the seed update is one add-xor-add per character.
// a zero character passes the front stage and queue before out_valid rises.
// a stalled output holds a zero character at the queue head; two more words
// are taken behind it, then in_ready drops. words ahead of it keep flowing.
module table_driven_string_hash_unit #(
  parameter int unsigned HASH_TYPES = 5
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  character,
  input  logic [2:0]  hash_type,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_value
);
  import tdsh_pkg::*;

  fill_wr_t   wr;
  logic       fill_done;
  logic       f_valid;
  logic       f_ready;
  hash_item_t f_item;
  logic       q_valid;
  logic       q_ready;
  hash_item_t q_item;

  tdsh_fill #(
    .HASH_TYPES(HASH_TYPES)
  ) u_fill (
    .clk (clk),
    .rst (rst),
    .wr  (wr),
    .done(fill_done)
  );

  tdsh_front #(
    .HASH_TYPES(HASH_TYPES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .fill_done (fill_done),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .character (character),
    .hash_type (hash_type),
    .item_valid(f_valid),
    .item_ready(f_ready),
    .item      (f_item)
  );

  tdsh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(f_valid),
    .push_ready(f_ready),
    .push_item (f_item),
    .pop_valid (q_valid),
    .pop_ready (q_ready),
    .pop_item  (q_item)
  );

  tdsh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .item_valid(q_valid),
    .item_ready(q_ready),
    .item      (q_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hash_value(hash_value)
  );

endmodule

// File: verif/tb_table_driven_string_hash_unit.sv
`timescale 1ns / 1ps

module tb_table_driven_string_hash_unit;
  import tdsh_pkg::*;

  localparam int unsigned HASH_TYPES = 5;
  localparam int unsigned ROM_WORDS = TABLE_ROWS * ROW_WORDS;
  localparam int unsigned RANDOM_ITEMS = 2000;

  typedef struct {
    logic [7:0] ch;
    logic [2:0] ht;
  } string_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  character = 8'h00;
  logic [2:0]  hash_type = 3'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] hash_value;

  logic [31:0]  mix_rom [0:ROM_WORDS-1];
  logic [31:0]  seed_one = SEED_ONE_START;
  logic [31:0]  seed_two = SEED_TWO_START;
  string_byte_t pending_bytes[$];
  logic [31:0]  hash_expected[$];
  int           sent_count = 0;
  int           mismatches = 0;

  table_driven_string_hash_unit #(.HASH_TYPES(HASH_TYPES)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .character (character),
    .hash_type (hash_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hash_value(hash_value)
  );

  always #5 clk = ~clk;

  // same word order as the hardware: column outer, row inner, two draws a word
  task automatic build_mix_rom();
    longint unsigned s;
    logic [31:0] hi;
    s = LCG_SEED;
    for (int col = 0; col < ROW_WORDS; col++) begin
      for (int row = 0; row < TABLE_ROWS; row++) begin
        s = (s * 125 + 3) % LCG_MOD;
        hi = {s[15:0], 16'h0000};
        s = (s * 125 + 3) % LCG_MOD;
        mix_rom[row * ROW_WORDS + col] = hi | {16'h0000, s[15:0]};
      end
    end
  endtask

  task automatic advance_seeds(input logic [7:0] ch_in, input logic [2:0] row);
    logic [7:0]  ch;
    logic [31:0] word;
    if (ch_in == CHAR_END) begin
      hash_expected.push_back(seed_one);
      seed_one = SEED_ONE_START;
      seed_two = SEED_TWO_START;
    end else begin
      ch = ch_in;
      if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
        ch = ch - CHAR_FOLD;
      // rows past the configured count read as zero
      word = (row < HASH_TYPES) ? mix_rom[row * ROW_WORDS + ch] : 32'h0;
      seed_one = word ^ (seed_one + seed_two);
      seed_two = {24'h0, ch} + seed_one + seed_two + (seed_two << 5) + SEED_TWO_INC;
    end
  endtask

  task automatic queue_byte(input logic [7:0] ch, input logic [2:0] ht);
    string_byte_t b;
    b.ch = ch;
    b.ht = ht;
    pending_bytes.push_back(b);
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: pick_char = 8'($urandom_range(8'h61, 8'h7A));
      4, 5:       pick_char = 8'($urandom_range(8'h41, 8'h5A));
      6, 7, 8:    pick_char = 8'($urandom_range(8'h20, 8'h7E));
      default:    pick_char = 8'($urandom_range(1, 255));
    endcase
  endfunction

  task automatic queue_random_strings();
    int total;
    int len;
    logic [2:0] row;
    logic mixed_rows;
    total = 0;
    while (total < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
      mixed_rows = ($urandom_range(0, 99) < 15);
      row = 3'($urandom_range(0, HASH_TYPES - 1));
      for (int i = 0; i < len; i++) begin
        if (mixed_rows)
          row = 3'($urandom_range(0, 7));
        queue_byte(pick_char(), row);
      end
      queue_byte(CHAR_END, 3'($urandom_range(0, 7)));
      total += len + 1;
    end
  endtask

  task automatic queue_directed();
    // empty string
    queue_byte(CHAR_END, 3'd0);
    // lower and upper case must hash alike
    queue_byte(8'h61, 3'd0);
    queue_byte(8'h7A, 3'd0);
    queue_byte(CHAR_END, 3'd0);
    queue_byte(8'h41, 3'd0);
    queue_byte(8'h5A, 3'd0);
    queue_byte(CHAR_END, 3'd0);
    // bytes just outside the letter ranges and the top of the byte range
    queue_byte(8'h60, 3'd1);
    queue_byte(8'h7B, 3'd1);
    queue_byte(8'h40, 3'd1);
    queue_byte(8'h5B, 3'd1);
    queue_byte(8'hFF, 3'd1);
    queue_byte(8'h80, 3'd1);
    queue_byte(8'h01, 3'd1);
    queue_byte(CHAR_END, 3'd1);
    // row changes inside one string, terminator row ignored
    queue_byte(8'h7F, 3'd2);
    queue_byte(8'h7F, 3'd3);
    queue_byte(8'h7F, 3'd4);
    queue_byte(CHAR_END, 3'd7);
    // rows past the table
    queue_byte(8'h55, 3'd5);
    queue_byte(8'hAA, 3'd6);
    queue_byte(8'hFF, 3'd7);
    queue_byte(CHAR_END, 3'd5);
  endtask

  // driver
  always @(posedge clk) begin
    string_byte_t b;
    logic calm;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        advance_seeds(character, hash_type);
        sent_count <= sent_count + 1;
      end
      calm = (sent_count >= 900 && sent_count < 1300);
      if (!(in_valid && !in_ready)) begin
        if (pending_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 8)) begin
          b = pending_bytes.pop_front();
          character <= b.ch;
          hash_type <= b.ht;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int   results_seen = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    logic [31:0] want;
    logic calm;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (hash_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected hash word %h", hash_value);
        end else begin
          want = hash_expected.pop_front();
          if (hash_value !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("hash mismatch: expected %h, got %h", want, hash_value);
          end
        end
      end
      // one long hold-off so terminators back up and stall the input
      if (!hold_done && results_seen >= 40) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
      calm = (sent_count >= 900 && sent_count < 1300);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 8);
      end
    end
  end

  initial begin
    build_mix_rom();
    queue_directed();
    queue_random_strings();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (pending_bytes.size() != 0 || in_valid)
      @(posedge clk);
    while (hash_expected.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("tb_table_driven_string_hash_unit: clean");
    else
      $display("tb_table_driven_string_hash_unit: errors");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_table_driven_string_hash_unit: errors");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/tdsh_pkg.sv
rtl/tdsh_fill.sv
rtl/tdsh_front.sv
rtl/tdsh_queue.sv
rtl/tdsh_back.sv
rtl/table_driven_string_hash_unit.sv
verif/tb_table_driven_string_hash_unit.sv
